// ----- rtl/vwit_pkg.sv -----
`timescale 1ns / 1ps

package vwit_pkg;

	localparam int KEY_W    = 32;
	localparam int INDEX_W  = 12;
	localparam int CORNER_W = 2;

	localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_CMP   = 4'b1000
	} state_t;

endpackage

// ----- rtl/vertex_weld_index_table.sv -----
`timescale 1ns / 1ps

// Vertex weld index table.
// Each input transfer carries one triangle corner as three float bit patterns
// (x_bits, y_bits, z_bits). Each one gives exactly one output transfer with the
// welded vertex index, the new and full flags, the corner position and the
// triangle completion mark. Keys match only on exact equality of all 96 bits.
// The table is a simple dual-port slot memory with linear probing. Each probe
// is a memory read followed by a compare, and the probe sequencer handles one
// corner at a time. At the final compare the result is written to the output
// register and the sequencer returns to idle, where the next corner is
// accepted. in_stall is high while a corner is being looked up.
// After reset the block sweeps the slot memory, clearing one slot per cycle,
// until every slot is cleared; in_stall stays high during that pass.
// The result sits in an output register. When out_stall holds it, the next
// corner is still accepted and probed, and its sequencer waits at the final
// compare until the output register is free.
module vertex_weld_index_table #(
	parameter int VERTEX_CAPACITY = 4096,
	parameter int TABLE_SLOTS     = 8192
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [vwit_pkg::KEY_W-1:0]        x_bits,
	input  logic [vwit_pkg::KEY_W-1:0]        y_bits,
	input  logic [vwit_pkg::KEY_W-1:0]        z_bits,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vwit_pkg::INDEX_W-1:0]      vertex_index,
	output logic                              is_new,
	output logic                              table_full,
	output logic [vwit_pkg::CORNER_W-1:0]     corner_pos,
	output logic                              triangle_done
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int NV_W   = $clog2(VERTEX_CAPACITY + 1);
	localparam int CAP_W  = $clog2(VERTEX_CAPACITY);
	localparam int ID_W   = (CAP_W < vwit_pkg::INDEX_W) ? CAP_W : vwit_pkg::INDEX_W;
	localparam int KW     = vwit_pkg::KEY_W;
	localparam int ENT_W  = 1 + 3 * KW + ID_W;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
	localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(TABLE_SLOTS);
	localparam logic [NV_W-1:0]   CAP_NV    = NV_W'(VERTEX_CAPACITY);

	logic [ENT_W-1:0] mem [TABLE_SLOTS];
	logic [ENT_W-1:0] rd_q;

	vwit_pkg::state_t state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] probe_q;
	logic [NV_W-1:0] next_vertex_q;
	logic [vwit_pkg::CORNER_W-1:0] corner_q;
	logic [KW-1:0] key_x_q;
	logic [KW-1:0] key_y_q;
	logic [KW-1:0] key_z_q;

	logic out_valid_q;
	logic [vwit_pkg::INDEX_W-1:0] out_index_q;
	logic out_new_q;
	logic out_full_q;
	logic [vwit_pkg::CORNER_W-1:0] out_corner_q;
	logic out_done_q;

	logic [KW-1:0] mixed;
	logic [SLOT_W-1:0] fold;
	logic [SLOT_W:0] fold_sub;
	logic [SLOT_W-1:0] home_slot;

	logic accept_in;
	logic out_free;
	logic rd_valid;
	logic rd_hit;
	logic room;
	logic finish;
	logic insert;
	logic res_full;
	logic [vwit_pkg::INDEX_W-1:0] res_index;

	logic mem_we;
	logic [SLOT_W-1:0] mem_wa;
	logic [ENT_W-1:0] mem_wd;

	// Home slot: y and z are rotated, XORed with x, folded down to the slot width and wrapped below TABLE_SLOTS.
	always_comb begin
		mixed = x_bits ^ {y_bits[20:0], y_bits[31:21]} ^ {z_bits[9:0], z_bits[31:10]};
		fold = '0;
		for (int i = 0; i < KW; i++) begin
			fold[i % SLOT_W] = fold[i % SLOT_W] ^ mixed[i];
		end
		fold_sub = {1'b0, fold} - SLOTS_EXT;
		home_slot = ({1'b0, fold} >= SLOTS_EXT) ? fold_sub[SLOT_W-1:0] : fold;
	end

	assign accept_in = in_valid && !in_stall;
	assign in_stall  = (state_q != vwit_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		rd_valid = rd_q[ENT_W-1];
		rd_hit = rd_valid
			&& (rd_q[ID_W+3*KW-1:ID_W+2*KW] == key_x_q)
			&& (rd_q[ID_W+2*KW-1:ID_W+KW] == key_y_q)
			&& (rd_q[ID_W+KW-1:ID_W] == key_z_q);
		room = (next_vertex_q < CAP_NV);
		finish = rd_hit || !rd_valid || (probe_q == LAST_SLOT);
		insert = !rd_valid && room;
		res_full = !rd_hit && !insert;
		if (rd_hit) begin
			res_index = vwit_pkg::INDEX_W'(rd_q[ID_W-1:0]);
		end else if (insert) begin
			res_index = vwit_pkg::INDEX_W'(next_vertex_q[ID_W-1:0]);
		end else begin
			res_index = '0;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = {1'b1, key_x_q, key_y_q, key_z_q, next_vertex_q[ID_W-1:0]};
		if (state_q == vwit_pkg::ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == vwit_pkg::ST_CMP && finish && out_free && insert) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vwit_pkg::ST_CLEAR;
			clr_q <= '0;
			next_vertex_q <= '0;
			corner_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !(state_q == vwit_pkg::ST_CMP && finish)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				vwit_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= vwit_pkg::ST_IDLE;
					end
				end
				vwit_pkg::ST_IDLE: begin
					if (accept_in) begin
						state_q <= vwit_pkg::ST_READ;
					end
				end
				vwit_pkg::ST_READ: begin
					state_q <= vwit_pkg::ST_CMP;
				end
				vwit_pkg::ST_CMP: begin
					if (!finish) begin
						state_q <= vwit_pkg::ST_READ;
					end else if (out_free) begin
						state_q <= vwit_pkg::ST_IDLE;
						out_valid_q <= 1'b1;
						corner_q <= (corner_q >= vwit_pkg::LAST_CORNER) ? '0 : corner_q + 1'b1;
						if (insert) begin
							next_vertex_q <= next_vertex_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= vwit_pkg::ST_CLEAR;
					clr_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			key_x_q <= x_bits;
			key_y_q <= y_bits;
			key_z_q <= z_bits;
			slot_q <= home_slot;
			probe_q <= '0;
		end else if (state_q == vwit_pkg::ST_CMP && !finish) begin
			slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
		if (state_q == vwit_pkg::ST_CMP && finish && out_free) begin
			out_index_q <= res_index;
			out_new_q <= insert;
			out_full_q <= res_full;
			out_corner_q <= corner_q;
			out_done_q <= (corner_q >= vwit_pkg::LAST_CORNER);
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_index  = out_index_q;
	assign is_new        = out_new_q;
	assign table_full    = out_full_q;
	assign corner_pos    = out_corner_q;
	assign triangle_done = out_done_q;

	a_vertex_count: assert property (@(posedge clk) disable iff (!arst_n)
		next_vertex_q <= CAP_NV)
		else $error("vertex count beyond capacity");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && table_full) && (!table_full || vertex_index == '0))
		else $error("inconsistent result flags");

	a_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (corner_pos <= vwit_pkg::LAST_CORNER)
			&& (triangle_done == (corner_pos == vwit_pkg::LAST_CORNER)))
		else $error("corner position out of step");

	a_new_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vwit_pkg::ST_CMP && finish && out_free && insert)
			|=> next_vertex_q == $past(next_vertex_q) + 1'b1)
		else $error("insert did not advance vertex count");

endmodule

// ----- tb/sv/vertex_weld_index_table_tb.sv -----
`timescale 1ns / 1ps

module vertex_weld_index_table_tb;

	localparam int VERTEX_CAPACITY  = 4096;
	localparam int TABLE_SLOTS      = 8192;
	localparam int QUIET_LIMIT      = 40000;
	localparam int DRAIN_CYCLES     = 64;
	localparam int RANDOM_PER_PHASE = 176;

	typedef logic [3*vwit_pkg::KEY_W-1:0] corner_key_t;

	typedef struct packed {
		logic [vwit_pkg::INDEX_W-1:0]  vertex_index;
		logic                          is_new;
		logic                          table_full;
		logic [vwit_pkg::CORNER_W-1:0] corner_pos;
		logic                          triangle_done;
	} weld_result_t;

	class weld_scoreboard;
		logic [vwit_pkg::INDEX_W-1:0]  vertex_of [corner_key_t];
		weld_result_t                  pending[$];
		int unsigned                   capacity;
		int unsigned                   stored;
		logic [vwit_pkg::CORNER_W-1:0] corner;
		int unsigned                   errors;

		function new(int unsigned cap);
			capacity = cap;
			stored   = 0;
			corner   = '0;
			errors   = 0;
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		function void note_corner(logic [vwit_pkg::KEY_W-1:0] x,
				logic [vwit_pkg::KEY_W-1:0] y, logic [vwit_pkg::KEY_W-1:0] z);
			corner_key_t  key;
			weld_result_t want;
			key  = {x, y, z};
			want = '0;
			if (vertex_of.exists(key)) begin
				want.vertex_index = vertex_of[key];
			end else if (stored < capacity) begin
				vertex_of[key]    = stored[vwit_pkg::INDEX_W-1:0];
				want.vertex_index = stored[vwit_pkg::INDEX_W-1:0];
				want.is_new       = 1'b1;
				stored++;
			end else begin
				want.table_full = 1'b1;
			end
			want.corner_pos    = corner;
			want.triangle_done = (corner == vwit_pkg::LAST_CORNER);
			corner = (corner == vwit_pkg::LAST_CORNER) ? '0 : corner + 1'b1;
			pending = {pending, want};
		endfunction

		task check_result(weld_result_t got);
			weld_result_t want;
			if (pending.size() == 0) begin
				report("result transfer with no corner outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.vertex_index !== want.vertex_index)
				report($sformatf("vertex_index %0d, expected %0d",
					got.vertex_index, want.vertex_index));
			if (got.is_new !== want.is_new)
				report($sformatf("is_new %b, expected %b", got.is_new, want.is_new));
			if (got.table_full !== want.table_full)
				report($sformatf("table_full %b, expected %b",
					got.table_full, want.table_full));
			if (got.corner_pos !== want.corner_pos)
				report($sformatf("corner_pos %0d, expected %0d",
					got.corner_pos, want.corner_pos));
			if (got.triangle_done !== want.triangle_done)
				report($sformatf("triangle_done %b, expected %b",
					got.triangle_done, want.triangle_done));
		endtask
	endclass

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [vwit_pkg::KEY_W-1:0]    x_bits   = '0;
	logic [vwit_pkg::KEY_W-1:0]    y_bits   = '0;
	logic [vwit_pkg::KEY_W-1:0]    z_bits   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [vwit_pkg::INDEX_W-1:0]  vertex_index;
	logic                          is_new;
	logic                          table_full;
	logic [vwit_pkg::CORNER_W-1:0] corner_pos;
	logic                          triangle_done;

	int unsigned    send_idle_pct = 0;
	int unsigned    recv_idle_pct = 0;
	int unsigned    quiet_cycles  = 0;
	corner_key_t    corner_pool[$];
	weld_scoreboard sb;

	logic [vwit_pkg::KEY_W-1:0] grid_coord [8] = '{32'h0000_0000, 32'h8000_0000,
		32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
		32'h7F7F_FFFF};

	vertex_weld_index_table #(
		.VERTEX_CAPACITY(VERTEX_CAPACITY),
		.TABLE_SLOTS(TABLE_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_bits(x_bits),
		.y_bits(y_bits),
		.z_bits(z_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.vertex_index(vertex_index),
		.is_new(is_new),
		.table_full(table_full),
		.corner_pos(corner_pos),
		.triangle_done(triangle_done)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_corner(x_bits, y_bits, z_bits);
		if (out_valid && !out_stall)
			sb.check_result(weld_result_t'({vertex_index, is_new, table_full,
				corner_pos, triangle_done}));
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("vertex_weld_index_table_tb NOT OK");
				$finish;
			end
		end
	end

	// Corners reused from those already sent, with grid values, near misses
	// one bit away from a known corner, and entirely random patterns.
	function automatic corner_key_t pick_corner();
		corner_key_t key;
		int unsigned kind;
		kind = (corner_pool.size() == 0) ? 9 : $urandom_range(9);
		if (kind <= 3) begin
			key = corner_pool[$urandom_range(corner_pool.size() - 1)];
		end else if (kind <= 5) begin
			key = {grid_coord[$urandom_range(7)], grid_coord[$urandom_range(7)],
				grid_coord[$urandom_range(7)]};
		end else if (kind == 6) begin
			key = corner_pool[$urandom_range(corner_pool.size() - 1)];
			key[$urandom_range(3*vwit_pkg::KEY_W - 1)] ^= 1'b1;
		end else begin
			key = {$urandom, $urandom, $urandom};
		end
		return key;
	endfunction

	task automatic send_corner(input corner_key_t key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{x_bits, y_bits, z_bits} <= key;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		corner_pool = {corner_pool, key};
	endtask

	initial begin
		sb = new(VERTEX_CAPACITY);
		send_idle_pct = 32;
		recv_idle_pct = 61;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		send_corner({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
		send_corner({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
		send_corner({32'h8000_0000, 32'h0000_0000, 32'h0000_0000});
		send_corner({32'h0000_0000, 32'h8000_0000, 32'h0000_0000});
		send_corner({32'h0000_0000, 32'h0000_0000, 32'h8000_0000});
		send_corner({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_corner({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_corner({32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000});
		send_corner({32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000});
		send_corner({32'hFFC0_0000, 32'h7FC0_0000, 32'h7FC0_0000});
		send_corner({32'h7F80_0001, 32'h7F80_0001, 32'h7F80_0001});
		send_corner({32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000});
		send_corner({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
		send_corner({32'h8000_0000, 32'h0000_0000, 32'h0000_0000});
		send_corner({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_corner({32'h3F80_0000, 32'h0000_0000, 32'h0000_0000});
		send_corner({32'h0000_0000, 32'h3F80_0000, 32'h0000_0000});
		send_corner({32'h0000_0000, 32'h0000_0000, 32'h3F80_0000});
		send_corner({32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
		send_corner({32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
		send_corner({32'h3F80_0000, 32'h0000_0000, 32'h0000_0000});

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 61 : 0;
			recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 32 : 0;
			repeat (RANDOM_PER_PHASE) send_corner(pick_corner());
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("vertex_weld_index_table_tb OK");
		else
			$display("vertex_weld_index_table_tb NOT OK");
		$finish;
	end

endmodule
